// ===== design/shfd_pkg.sv =====
// Shared constants and types for the sync header frame deframer.
`default_nettype none

package shfd_pkg;

   localparam int unsigned BYTE_W        = 8;
   localparam int unsigned POS_W         = 6;
   localparam int unsigned TRAILER_BYTES = 4;

   localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'hAA;
   localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h55;
   localparam logic [BYTE_W-1:0] PAD_BYTE   = 8'h00;

   typedef logic [BYTE_W-1:0] byte_type;

endpackage : shfd_pkg

`default_nettype wire

// ===== design/shfd_cell.sv =====
// One byte cell of the frame shift chain.
`default_nettype none

module shfd_cell (
   input  wire logic              clock,
   input  wire logic              shift_en,
   input  wire shfd_pkg::byte_type data_in,
   output shfd_pkg::byte_type     data_out
);

   shfd_pkg::byte_type data_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         data_ff <= data_in;
      end
   end

   assign data_out = data_ff;

endmodule : shfd_cell

`default_nettype wire

// ===== design/sync_header_frame_deframer_unit.sv =====
// Top level of the sync header frame deframer: control and cell chain.
//
// Usage:
//   req_* carries one received byte per item. While csr listen enable is
//   clear the byte is accepted and dropped. Bytes are hunted for an AA 55
//   header and then collected into a chain of FRAME_BYTES byte cells, each
//   new byte entering at the tail and the chain shifting toward the head.
//   When the frame is full the block checks the header and the four
//   trailer bytes in its check state; a good frame is then shifted out of
//   the head cell on rsp_*, one item per cycle while rsp_tready is high,
//   tlast on the final byte. req_tready is low from the check state until
//   the last byte is taken, or until the check ends for a bad frame; a
//   stall on rsp simply holds the chain and the current item.
//   rsp_tvalid is registered and rises once the check state has passed
//   the frame; the first result can be taken from then on.
//   Reset (synchronous, active high) clears listen enable, the fill count
//   and the output valid; the cell contents are not cleared.
`default_nettype none

module sync_header_frame_deframer_unit #(
   parameter int unsigned FRAME_BYTES = 33
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [15:0] rsp_tdata,   // [7:0] frame_byte, [13:8] byte_position, [15:14] 0
   output      logic        rsp_tlast,   // last_of_frame
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data  // listen_enable
);

   localparam int unsigned CW = $clog2(FRAME_BYTES);
   localparam logic [CW-1:0] LAST_IDX = CW'(FRAME_BYTES - 1);

   typedef enum logic [1:0] {
      ST_COLLECT,
      ST_CHECK,
      ST_EMIT
   } state_type;

   state_type      state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  pos_ff, pos_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           listen_ff;
   logic           store_shift, emit_shift, shift_en;
   logic           frame_ok;

   shfd_pkg::byte_type cell_q [FRAME_BYTES];

   // cell chain
   for (genvar i = 0; i < FRAME_BYTES; i++) begin : g_cell
      shfd_pkg::byte_type cell_d;
      if (i == FRAME_BYTES - 1) begin : g_tail
         assign cell_d = req_tdata;
      end else begin : g_body
         assign cell_d = cell_q[i+1];
      end
      shfd_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .data_in  (cell_d),
         .data_out (cell_q[i])
      );
   end

   always_comb begin
      frame_ok = (cell_q[0] == shfd_pkg::HDR_FIRST) && (cell_q[1] == shfd_pkg::HDR_SECOND);
      for (int k = 0; k < shfd_pkg::TRAILER_BYTES; k++) begin
         if (cell_q[FRAME_BYTES - shfd_pkg::TRAILER_BYTES + k] != shfd_pkg::PAD_BYTE) begin
            frame_ok = 1'b0;
         end
      end
   end

   assign req_tready = (state_ff == ST_COLLECT);
   assign shift_en   = store_shift | emit_shift;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      store_shift  = 1'b0;
      emit_shift   = 1'b0;
      unique case (state_ff)
         ST_COLLECT: begin
            if (req_tvalid && listen_ff) begin
               if (count_ff == '0) begin
                  if (req_tdata == shfd_pkg::HDR_FIRST) begin
                     store_shift = 1'b1;
                     count_in    = CW'(1);
                  end
               end else if (count_ff == CW'(1)) begin
                  if (req_tdata == shfd_pkg::HDR_SECOND) begin
                     store_shift = 1'b1;
                     count_in    = CW'(2);
                  end else if (req_tdata != shfd_pkg::HDR_FIRST) begin
                     count_in = '0;
                  end
               end else begin
                  store_shift = 1'b1;
                  if (count_ff == LAST_IDX) begin
                     count_in = '0;
                     state_in = ST_CHECK;
                  end else begin
                     count_in = count_ff + CW'(1);
                  end
               end
            end
         end
         ST_CHECK: begin
            pos_in = '0;
            if (frame_ok) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_EMIT;
            end else begin
               state_in = ST_COLLECT;
            end
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               emit_shift = 1'b1;
               if (pos_ff == LAST_IDX) begin
                  rsp_valid_in = 1'b0;
                  state_in     = ST_COLLECT;
               end else begin
                  pos_in = pos_ff + CW'(1);
               end
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         count_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         listen_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            listen_ff <= csr_wr_data;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, shfd_pkg::POS_W'(pos_ff), cell_q[0]};
   assign rsp_tlast  = (pos_ff == LAST_IDX);

   // checks
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while a frame is being emitted");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid && req_tready)
      else $error("emit did not end after the last item");

   a_start_header: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> (rsp_tdata[7:0] == shfd_pkg::HDR_FIRST) && (pos_ff == '0))
      else $error("frame emit did not start at the header");

endmodule : sync_header_frame_deframer_unit

`default_nettype wire
